// ===== src/prlm_pkg.sv =====
package prlm_pkg;

  localparam int SAMPLE_W      = 16;
  localparam int LEVEL_W       = 16;
  localparam int COUNT_W       = 20;
  localparam int SUM_W         = 50;
  localparam int SKIP_W        = 16;
  localparam int INDEX_BITS_DEF = 20;

  // Quotient of sum by count never exceeds 2^30, so the root takes 16 steps
  // over the low 32 bits of the quotient.
  localparam int RAD_W       = 32;
  localparam int DIV_STEPS   = SUM_W;
  localparam int SQRT_STEPS  = RAD_W / 2;
  localparam int STEP_W      = $clog2(DIV_STEPS);

  localparam int ADDR_W      = 3;
  localparam int DATA_W      = 32;
  localparam logic REG_SKIP  = 1'b0;
  localparam logic [SKIP_W-1:0] SKIP_RESET = 16'd800;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] sample;
    logic                       last;
  } in_item_t;

  typedef struct packed {
    logic [LEVEL_W-1:0] peak_magnitude;
    logic [LEVEL_W-1:0] rms_level;
    logic [COUNT_W-1:0] samples_counted;
    logic               overflow;
  } out_item_t;

  typedef struct packed {
    logic accept;
    logic start;
    logic div_step;
    logic sqrt_step;
    logic out_load;
  } dp_cmd_t;

  typedef struct packed {
    logic out_valid;
  } dp_sts_t;

endpackage

// ===== src/prlm_ctrl.sv =====
module prlm_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  input  logic              in_last,
  input  logic              out_stall,
  input  prlm_pkg::dp_sts_t sts,
  output logic              in_stall,
  output prlm_pkg::dp_cmd_t cmd
);
  import prlm_pkg::*;

  localparam logic [1:0] S_ACC  = 2'd0;
  localparam logic [1:0] S_DIV  = 2'd1;
  localparam logic [1:0] S_SQRT = 2'd2;
  localparam logic [1:0] S_HOLD = 2'd3;

  logic [1:0]        state_r, state_nxt;
  logic [STEP_W-1:0] step_r, step_nxt;

  always_comb begin
    state_nxt = state_r;
    step_nxt  = step_r;
    cmd       = '0;
    in_stall  = 1'b1;
    case (state_r)
      S_ACC: begin
        in_stall   = 1'b0;
        cmd.accept = in_valid;
        if (in_valid && in_last) begin
          cmd.start = 1'b1;
          step_nxt  = '0;
          state_nxt = S_DIV;
        end
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        if (step_r == STEP_W'(DIV_STEPS - 1)) begin
          step_nxt  = '0;
          state_nxt = S_SQRT;
        end else begin
          step_nxt = step_r + 1'b1;
        end
      end
      S_SQRT: begin
        cmd.sqrt_step = 1'b1;
        if (step_r == STEP_W'(SQRT_STEPS - 1)) begin
          step_nxt  = '0;
          state_nxt = S_HOLD;
        end else begin
          step_nxt = step_r + 1'b1;
        end
      end
      S_HOLD: begin
        // The result register must be empty or emptying this cycle.
        if (!sts.out_valid || !out_stall) begin
          cmd.out_load = 1'b1;
          state_nxt    = S_ACC;
        end
      end
      default: begin
        state_nxt = S_ACC;
        step_nxt  = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_ACC;
      step_r  <= '0;
    end else begin
      state_r <= state_nxt;
      step_r  <= step_nxt;
    end
  end

endmodule

// ===== src/prlm_dp.sv =====
module prlm_dp #(
  parameter int INDEX_BITS = prlm_pkg::INDEX_BITS_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  prlm_pkg::dp_cmd_t           cmd,
  input  prlm_pkg::in_item_t          in_data,
  input  logic [prlm_pkg::SKIP_W-1:0] skip,
  input  logic                        out_stall,
  output prlm_pkg::dp_sts_t           sts,
  output logic                        out_valid,
  output prlm_pkg::out_item_t         out_data
);
  import prlm_pkg::*;

  localparam int CMP_W = (INDEX_BITS > SKIP_W) ? INDEX_BITS : SKIP_W;

  logic [INDEX_BITS-1:0] idx_r, idx_nxt;
  logic [LEVEL_W-1:0]    peak_r, peak_nxt;
  logic [SUM_W-1:0]      sum_r, sum_nxt;
  logic [COUNT_W-1:0]    cnt_r, cnt_nxt;
  logic                  sat_r, sat_nxt;

  logic [LEVEL_W-1:0]    peak_snap_r;
  logic [COUNT_W-1:0]    cnt_snap_r;
  logic                  sat_snap_r;

  logic [COUNT_W-1:0]    rem_r, rem_nxt;
  logic [SUM_W-1:0]      quo_r;
  logic [LEVEL_W:0]      srem_r, srem_nxt;
  logic [LEVEL_W-1:0]    root_r;

  out_item_t             out_r;
  logic                  out_valid_r, out_valid_nxt;

  logic [SAMPLE_W-1:0]   raw;
  logic [LEVEL_W-1:0]    mag;
  logic [2*LEVEL_W-1:0]  square;
  logic                  past_skip, count_full, idx_at_max, take;

  logic [COUNT_W:0]      div_trial, div_diff;
  logic                  div_fits;
  logic [LEVEL_W+2:0]    sq_cat, sq_trial;
  logic                  sq_fits;

  // Per-sample accumulation.
  always_comb begin
    raw        = in_data.sample;
    mag        = raw[SAMPLE_W-1] ? (~raw + 1'b1) : raw;
    square     = mag * mag;
    past_skip  = CMP_W'(idx_r) >= CMP_W'(skip);
    count_full = &cnt_r;
    idx_at_max = &idx_r;
    take       = past_skip && !count_full;

    peak_nxt = (take && (mag > peak_r)) ? mag : peak_r;
    sum_nxt  = take ? sum_r + SUM_W'(square) : sum_r;
    cnt_nxt  = take ? cnt_r + 1'b1 : cnt_r;
    sat_nxt  = sat_r | (past_skip & count_full) | idx_at_max;
    idx_nxt  = idx_at_max ? idx_r : idx_r + 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r  <= '0;
      peak_r <= '0;
      sum_r  <= '0;
      cnt_r  <= '0;
      sat_r  <= 1'b0;
    end else if (cmd.accept) begin
      if (cmd.start) begin
        idx_r  <= '0;
        peak_r <= '0;
        sum_r  <= '0;
        cnt_r  <= '0;
        sat_r  <= 1'b0;
      end else begin
        idx_r  <= idx_nxt;
        peak_r <= peak_nxt;
        sum_r  <= sum_nxt;
        cnt_r  <= cnt_nxt;
        sat_r  <= sat_nxt;
      end
    end
  end

  // Restoring division, one quotient bit a cycle. The dividend shifts out of
  // the top of quo_r while quotient bits enter at the bottom.
  always_comb begin
    div_trial = {rem_r, quo_r[SUM_W-1]};
    div_diff  = div_trial - {1'b0, cnt_snap_r};
    div_fits  = div_trial >= {1'b0, cnt_snap_r};
    rem_nxt   = div_fits ? div_diff[COUNT_W-1:0] : div_trial[COUNT_W-1:0];
  end

  // Digit-by-digit square root, two radicand bits a cycle taken from the top
  // of the low RAD_W bits of the quotient.
  always_comb begin
    sq_cat   = {srem_r, quo_r[RAD_W-1:RAD_W-2]};
    sq_trial = {1'b0, root_r, 2'b01};
    sq_fits  = sq_cat >= sq_trial;
    srem_nxt = sq_fits ? LEVEL_W'(sq_cat - sq_trial) + (LEVEL_W+1)'(0)
                       : sq_cat[LEVEL_W:0];
  end

  always_ff @(posedge clk) begin
    if (cmd.start) begin
      peak_snap_r <= peak_nxt;
      cnt_snap_r  <= cnt_nxt;
      sat_snap_r  <= sat_nxt;
      quo_r       <= sum_nxt;
      rem_r       <= '0;
      srem_r      <= '0;
      root_r      <= '0;
    end else if (cmd.div_step) begin
      quo_r <= {quo_r[SUM_W-2:0], div_fits};
      rem_r <= rem_nxt;
    end else if (cmd.sqrt_step) begin
      quo_r  <= {quo_r[SUM_W-3:0], 2'b00};
      srem_r <= srem_nxt;
      root_r <= {root_r[LEVEL_W-2:0], sq_fits};
    end
  end

  // Result register.
  assign out_valid_nxt = cmd.out_load | (out_valid_r & out_stall);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_r.peak_magnitude  <= peak_snap_r;
      out_r.rms_level       <= (cnt_snap_r == '0) ? '0 : root_r;
      out_r.samples_counted <= cnt_snap_r;
      out_r.overflow        <= sat_snap_r;
    end
  end

  assign sts.out_valid = out_valid_r;
  assign out_valid     = out_valid_r;
  assign out_data      = out_r;

endmodule

// ===== src/peak_rms_level_meter.sv =====
// Peak and RMS level meter for recorded audio.
// Input channel (in_valid, in_stall, in_data): one signed 16-bit sample per
// request, with last marking the final sample of a recording. Samples are
// taken at one per cycle while a recording accumulates.
// Output channel (out_valid, out_stall, out_data): one result per recording,
// holding peak magnitude, floor(sqrt(sum of squares / count)), the count of
// measured samples and an overflow flag.
// After the request marked last, in_stall stays high while a bit-serial
// divider and a digit-serial square root run and the result register is
// loaded; input resumes in the same cycle that the result appears.
// A held result waits in its register while the next recording accumulates;
// if it is still stalled when the next result is ready, input stays stalled.
// Register skip_samples (byte address 0) sets how many leading samples of
// each recording are ignored. Reset restores it to 800, clears the running
// measurement state and marks the result register empty.
module peak_rms_level_meter #(
  parameter int INDEX_BITS = prlm_pkg::INDEX_BITS_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  prlm_pkg::in_item_t          in_data,
  output logic                        out_valid,
  input  logic                        out_stall,
  output prlm_pkg::out_item_t         out_data,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [prlm_pkg::ADDR_W-1:0] paddr,
  input  logic [prlm_pkg::DATA_W-1:0] pwdata,
  output logic [prlm_pkg::DATA_W-1:0] prdata,
  output logic                        pready
);
  import prlm_pkg::*;

  logic [SKIP_W-1:0] skip_r;
  logic              skip_wr;
  dp_cmd_t           cmd;
  dp_sts_t           sts;

  assign pready  = 1'b1;
  assign skip_wr = psel && penable && pwrite && pready && (paddr[2] == REG_SKIP);
  assign prdata  = (paddr[2] == REG_SKIP) ? DATA_W'(skip_r) : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      skip_r <= SKIP_RESET;
    end else if (skip_wr) begin
      skip_r <= pwdata[SKIP_W-1:0];
    end
  end

  prlm_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_last   (in_data.last),
    .out_stall (out_stall),
    .sts       (sts),
    .in_stall  (in_stall),
    .cmd       (cmd)
  );

  prlm_dp #(
    .INDEX_BITS (INDEX_BITS)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .in_data   (in_data),
    .skip      (skip_r),
    .out_stall (out_stall),
    .sts       (sts),
    .out_valid (out_valid),
    .out_data  (out_data)
  );

  // The unit is busy as soon as a final sample has been taken.
  a_busy_after_last: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall && in_data.last |=> in_stall)
    else $error("input not stalled after final sample");

  // A new result is only loaded while the input side is held off.
  a_result_while_stalled: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(in_stall))
    else $error("result produced while input was open");

  a_rms_below_peak: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_data.rms_level <= out_data.peak_magnitude)
    else $error("rms level above peak");

  a_empty_result: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_data.samples_counted == '0) |->
      (out_data.peak_magnitude == '0) && (out_data.rms_level == '0))
    else $error("non-zero levels with nothing counted");

endmodule

// ===== test/peak_rms_level_meter_tb.sv =====
`timescale 1ns / 100ps

module peak_rms_level_meter_tb;
  import prlm_pkg::*;

  localparam int INDEX_BITS = INDEX_BITS_DEF;
  localparam int INDEX_MAX = 2 ** INDEX_BITS - 1;
  localparam logic [ADDR_W-1:0] SKIP_ADDR = {REG_SKIP, 2'b00};
  localparam int DRAIN_HOLD = 70;
  localparam int QUIET_LIMIT = 3000;

  typedef enum logic [1:0] {WAVE_FULL, WAVE_EDGE, WAVE_QUIET, WAVE_FLAT} wave_t;
  typedef enum logic [1:0] {FLOW_FREE, FLOW_COIN, FLOW_HEAVY, FLOW_LIGHT} flow_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  in_item_t in_data = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  out_item_t out_data;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [ADDR_W-1:0] paddr = '0;
  logic [DATA_W-1:0] pwdata = '0;
  logic [DATA_W-1:0] prdata;
  logic pready;

  in_item_t sample_queue[$];
  out_item_t level_queue[$];
  int requests_queued = 0;
  int requests_taken = 0;
  int fail_count = 0;

  // Shadow of the meter: setting and running measurement of one recording.
  logic [SKIP_W-1:0] skip_setting = SKIP_RESET;
  logic [INDEX_BITS-1:0] rec_index = '0;
  logic [LEVEL_W-1:0] rec_peak = '0;
  logic [SUM_W-1:0] rec_sumsq = '0;
  logic [COUNT_W-1:0] rec_count = '0;
  logic rec_sat = 1'b0;

  int burst_left = 0;
  int gap_left = 0;
  flow_t flow_mode = FLOW_FREE;
  int flow_left = 0;
  int quiet_cycles = 0;

  peak_rms_level_meter #(.INDEX_BITS(INDEX_BITS)) i_dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  always #6 clk = ~clk;

  function automatic logic [LEVEL_W-1:0] floor_root(logic [SUM_W-1:0] v);
    logic [LEVEL_W-1:0] root;
    logic [LEVEL_W-1:0] trial;
    root = '0;
    for (int b = LEVEL_W - 1; b >= 0; b--) begin
      trial = root | (LEVEL_W'(1) << b);
      if (SUM_W'(trial) * SUM_W'(trial) <= v) root = trial;
    end
    return root;
  endfunction

  // Advances the shadow by one accepted request and queues the level
  // report that a request marked last produces.
  function automatic void measure_sample(in_item_t item);
    logic [LEVEL_W-1:0] mag;
    out_item_t report;
    mag = item.sample[SAMPLE_W-1] ? LEVEL_W'(-item.sample) : LEVEL_W'(item.sample);
    if (rec_index >= skip_setting) begin
      if (rec_count == '1) begin
        rec_sat = 1'b1;
      end else begin
        if (mag > rec_peak) rec_peak = mag;
        rec_sumsq = rec_sumsq + SUM_W'(mag) * SUM_W'(mag);
        rec_count = rec_count + 1'b1;
      end
    end
    if (rec_index == INDEX_BITS'(INDEX_MAX)) rec_sat = 1'b1;
    else rec_index = rec_index + 1'b1;
    requests_taken++;
    if (item.last) begin
      report.peak_magnitude = rec_peak;
      report.rms_level = (rec_count == '0) ? '0 : floor_root(rec_sumsq / SUM_W'(rec_count));
      report.samples_counted = rec_count;
      report.overflow = rec_sat;
      level_queue.push_back(report);
      rec_index = '0;
      rec_peak = '0;
      rec_sumsq = '0;
      rec_count = '0;
      rec_sat = 1'b0;
    end
  endfunction

  task automatic check_field(string name, longint unsigned want, longint unsigned got);
    if (want != got) begin
      $display("%0t: %s expected %0d actual %0d", $time, name, want, got);
      fail_count++;
    end
  endtask

  task automatic check_report(out_item_t got);
    out_item_t want;
    if (level_queue.size() == 0) begin
      $display("%0t: level report expected none actual peak %0d rms %0d count %0d ovf %0d",
               $time, got.peak_magnitude, got.rms_level, got.samples_counted, got.overflow);
      fail_count++;
    end else begin
      want = level_queue.pop_front();
      check_field("peak_magnitude", want.peak_magnitude, got.peak_magnitude);
      check_field("rms_level", want.rms_level, got.rms_level);
      check_field("samples_counted", want.samples_counted, got.samples_counted);
      check_field("overflow", want.overflow, got.overflow);
    end
  endtask

  // Sender: bursts of random length separated by random gaps.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      burst_left <= 0;
      gap_left <= 0;
    end else if (!in_valid || !in_stall) begin
      if (gap_left != 0 || sample_queue.size() == 0) begin
        in_valid <= 1'b0;
        if (gap_left != 0) gap_left <= gap_left - 1;
      end else begin
        in_valid <= 1'b1;
        in_data <= sample_queue.pop_front();
        if (burst_left <= 1) begin
          burst_left <= $urandom_range(1, 40);
          gap_left <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
        end else begin
          burst_left <= burst_left - 1;
        end
      end
    end
  end

  // Receiver: the stall behaviour switches at random among free, coin-toss, heavy and light stalling.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
      flow_mode <= FLOW_FREE;
      flow_left <= 100;
    end else begin
      if (flow_left == 0) begin
        flow_mode <= flow_t'($urandom_range(0, 3));
        flow_left <= $urandom_range(50, 400);
      end else begin
        flow_left <= flow_left - 1;
      end
      case (flow_mode)
        FLOW_FREE: out_stall <= 1'b0;
        FLOW_COIN: out_stall <= ($urandom_range(0, 1) == 1);
        FLOW_HEAVY: out_stall <= ($urandom_range(0, 7) != 0);
        default: out_stall <= ($urandom_range(0, 15) == 0);
      endcase
    end
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && !in_stall) measure_sample(in_data);
      if (out_valid && !out_stall) check_report(out_data);
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall) || psel) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == QUIET_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic push_item(logic signed [SAMPLE_W-1:0] sample, logic last);
    in_item_t item;
    item.sample = sample;
    item.last = last;
    sample_queue.push_back(item);
    requests_queued++;
  endtask

  // Waits until every request has been taken and every report has arrived,
  // then leaves the meter time to settle before any register access.
  task automatic drain();
    while (requests_taken != requests_queued || level_queue.size() != 0) @(posedge clk);
    repeat (DRAIN_HOLD) @(posedge clk);
  endtask

  task automatic write_skip(logic [SKIP_W-1:0] value);
    @(posedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= SKIP_ADDR;
    pwdata <= DATA_W'(value);
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    skip_setting = value;
    penable <= 1'b0;
    pwrite <= 1'b0;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (prdata !== DATA_W'(value)) begin
      $display("%0t: skip_samples read expected %0d actual %0d", $time, value, prdata);
      fail_count++;
    end
    psel <= 1'b0;
    penable <= 1'b0;
  endtask

  function automatic logic signed [SAMPLE_W-1:0] pick_sample(wave_t wave,
                                                            logic signed [SAMPLE_W-1:0] flat);
    case (wave)
      WAVE_FULL: return SAMPLE_W'($urandom);
      WAVE_EDGE: begin
        case ($urandom_range(0, 5))
          0: return 16'sh8000;
          1: return 16'sh7FFF;
          2: return 16'sh0000;
          3: return 16'sh0001;
          4: return 16'shFFFF;
          default: return 16'sh8001;
        endcase
      end
      WAVE_QUIET: return SAMPLE_W'(int'($urandom_range(0, 64)) - 32);
      default: return flat;
    endcase
  endfunction

  task automatic record_batch(int recordings, int min_len, int max_len);
    int len;
    wave_t wave;
    logic signed [SAMPLE_W-1:0] flat;
    for (int r = 0; r < recordings; r++) begin
      len = $urandom_range(min_len, max_len);
      wave = wave_t'($urandom_range(0, 3));
      flat = pick_sample(WAVE_FULL, '0);
      for (int i = 0; i < len; i++) push_item(pick_sample(wave, flat), i == len - 1);
    end
    drain();
  endtask

  initial begin
    int setting;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    // Out of reset the skip covers these recordings entirely.
    push_item(16'sh8000, 1'b0);
    push_item(16'sh7FFF, 1'b0);
    push_item(16'sh1234, 1'b1);
    push_item(16'sh8000, 1'b1);
    drain();
    record_batch(1, SKIP_RESET + 1, SKIP_RESET + 20);

    write_skip('0);
    push_item(16'sh8000, 1'b1);
    push_item(16'sh7FFF, 1'b1);
    push_item(16'sh0000, 1'b1);
    push_item(16'shFFFF, 1'b0);
    push_item(16'sh0001, 1'b1);
    push_item(16'sh8000, 1'b0);
    push_item(16'sh7FFF, 1'b0);
    push_item(16'sh0000, 1'b0);
    push_item(16'sh8001, 1'b0);
    push_item(16'sh8000, 1'b1);
    push_item(16'sh5555, 1'b0);
    push_item(16'shAAAA, 1'b1);
    drain();
    record_batch(8, 1, 10);

    write_skip(16'd1);
    record_batch(8, 1, 8);
    write_skip(16'd2);
    record_batch(6, 1, 12);
    write_skip(16'd7);
    record_batch(6, 4, 16);
    setting = $urandom_range(3, 40);
    write_skip(SKIP_W'(setting));
    record_batch(4, 1, setting + 12);
    write_skip(16'hFFFF);
    record_batch(3, 1, 20);

    write_skip(16'd5);
    record_batch(5, 1, 20);

    if (fail_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
